// ----- design/bis_pkg.sv -----
// shared types and constants for the binary insertion sorter
package bis_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic [POS_W-1:0]         position;
        logic                     last_res;
        logic                     overflow;
    } out_item_t;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift_lo;
        logic shift_hi;
    } cell_ctrl_t;

endpackage

// ----- design/bis_cell.sv -----
// one storage cell of the insertion chain: holds one sorted entry
module bis_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bis_pkg::cell_ctrl_t           ctrl,
    input  logic signed [VALUE_BITS-1:0]  new_value,
    input  logic [bis_pkg::POS_W-1:0]     new_pos,
    input  logic                          left_valid,
    input  logic signed [VALUE_BITS-1:0]  left_value,
    input  logic [bis_pkg::POS_W-1:0]     left_pos,
    input  logic                          left_gt,
    input  logic                          left_settled,
    input  logic                          right_valid,
    input  logic signed [VALUE_BITS-1:0]  right_value,
    input  logic [bis_pkg::POS_W-1:0]     right_pos,
    output logic                          valid,
    output logic signed [VALUE_BITS-1:0]  value,
    output logic [bis_pkg::POS_W-1:0]     pos,
    output logic                          gt,
    output logic                          settled
);
    import bis_pkg::*;

    logic                         valid_reg, valid_next;
    logic signed [VALUE_BITS-1:0] value_reg, value_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic                         take_new;

    // strictly greater keeps equal values in arrival order
    assign gt       = valid_reg && (new_value < value_reg);
    assign settled  = valid_reg && !gt;
    assign take_new = (!valid_reg || gt) && left_settled;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        if (ctrl.insert)
        begin
            if (left_gt)
            begin
                valid_next = left_valid;
                value_next = left_value;
                pos_next   = left_pos;
            end
            else if (take_new)
            begin
                valid_next = 1'b1;
                value_next = new_value;
                pos_next   = new_pos;
            end
        end
        else if (ctrl.shift_lo)
        begin
            valid_next = right_valid;
            value_next = right_value;
            pos_next   = right_pos;
        end
        else if (ctrl.shift_hi)
        begin
            valid_next = left_valid;
            value_next = left_value;
            pos_next   = left_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign pos   = pos_reg;

endmodule

// ----- design/binary_insertion_sorter_top.sv -----
// top level of the binary insertion sorter: cell chain, drain control, output register
//
// Values arrive one per transfer and are inserted into a row of MAX_ITEMS cells that
// stays sorted ascending; an equal value goes after those already held, so order is
// stable. On each insertion every cell compares against the broadcast value and
// either keeps its entry, takes the new one, or takes its left neighbor's, so a new
// value may be accepted every cycle while filling. When the value marked last has
// been taken, input is held off and the chain drains through the output register,
// one result per cycle while the consumer is ready. With ascending = 1 results leave
// from the low end of the chain; with ascending = 0 the chain shifts toward the high
// end and results leave from there, which first costs idle shifts until the list
// reaches the top cell. Each result carries the arrival position, a last flag on the
// final result and an overflow flag set on every result of a list in which values
// past MAX_ITEMS were dropped. Input is accepted again as soon as the final result
// has been loaded into the output register. The ascending register may be written
// only while the block is idle.
module binary_insertion_sorter_top #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bis_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bis_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import bis_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    // chain taps, one entry per cell
    logic [MAX_ITEMS-1:0]         occ;
    logic [MAX_ITEMS-1:0]         gt_vec;
    logic [MAX_ITEMS-1:0]         settled_vec;
    logic signed [VALUE_BITS-1:0] vals [MAX_ITEMS];
    logic [POS_W-1:0]             poss [MAX_ITEMS];

    logic                         asc_reg;
    logic                         drain_reg, drain_next;
    logic                         ovf_seen_reg, ovf_seen_next;
    logic                         drain_ovf_reg, drain_ovf_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;
    out_item_t                    out_data_reg, out_data_next;

    logic                         in_fire;
    logic                         full;
    logic                         step;
    logic                         load;
    logic                         is_final;
    cell_ctrl_t                   ctrl;
    logic signed [VALUE_BITS-1:0] new_value;
    logic [POS_W-1:0]             new_pos;
    logic signed [VALUE_BITS-1:0] sel_value;
    logic [DATA_W-1:0]            sel_value_out;

    // input value resized to the internal compare width
    generate
        if (VALUE_BITS <= DATA_W)
        begin : g_in_narrow
            assign new_value     = in_data.value[VALUE_BITS-1:0];
            assign sel_value_out = DATA_W'(unsigned'(sel_value));
        end
        else
        begin : g_in_wide
            assign new_value     = {{(VALUE_BITS-DATA_W){in_data.value[DATA_W-1]}},
                                    in_data.value};
            assign sel_value_out = sel_value[DATA_W-1:0];
        end

        // arrival position keeps only its low bits, or is zero-extended when the counter is narrower
        if (CNT_W > POS_W)
        begin : g_pos_trunc
            assign new_pos = cnt_reg[POS_W-1:0];
        end
        else
        begin : g_pos_ext
            assign new_pos = POS_W'(cnt_reg);
        end
    endgenerate

    // handshakes
    assign in_ready  = !drain_reg;
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign full      = occ[MAX_ITEMS-1];

    // drain advances when the output register is free or being emptied
    assign step     = drain_reg && (!out_valid_reg || out_ready);
    // descending drain only emits once the list has reached the top cell
    assign load     = step && (asc_reg || occ[MAX_ITEMS-1]);
    assign is_final = asc_reg ? !occ[1] : !occ[MAX_ITEMS-2];

    assign ctrl.insert   = in_fire && !full;
    assign ctrl.shift_lo = step && asc_reg;
    assign ctrl.shift_hi = step && !asc_reg;

    assign sel_value = asc_reg ? vals[0] : vals[MAX_ITEMS-1];

    // the cell chain
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            logic                         l_valid;
            logic signed [VALUE_BITS-1:0] l_value;
            logic [POS_W-1:0]             l_pos;
            logic                         l_gt;
            logic                         l_settled;
            logic                         r_valid;
            logic signed [VALUE_BITS-1:0] r_value;
            logic [POS_W-1:0]             r_pos;

            if (gi == 0)
            begin : g_left_edge
                assign l_valid   = 1'b0;
                assign l_value   = '0;
                assign l_pos     = '0;
                assign l_gt      = 1'b0;
                assign l_settled = 1'b1;
            end
            else
            begin : g_left
                assign l_valid   = occ[gi-1];
                assign l_value   = vals[gi-1];
                assign l_pos     = poss[gi-1];
                assign l_gt      = gt_vec[gi-1];
                assign l_settled = settled_vec[gi-1];
            end

            if (gi == MAX_ITEMS - 1)
            begin : g_right_edge
                assign r_valid = 1'b0;
                assign r_value = '0;
                assign r_pos   = '0;
            end
            else
            begin : g_right
                assign r_valid = occ[gi+1];
                assign r_value = vals[gi+1];
                assign r_pos   = poss[gi+1];
            end

            bis_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .new_value    (new_value),
                .new_pos      (new_pos),
                .left_valid   (l_valid),
                .left_value   (l_value),
                .left_pos     (l_pos),
                .left_gt      (l_gt),
                .left_settled (l_settled),
                .right_valid  (r_valid),
                .right_value  (r_value),
                .right_pos    (r_pos),
                .valid        (occ[gi]),
                .value        (vals[gi]),
                .pos          (poss[gi]),
                .gt           (gt_vec[gi]),
                .settled      (settled_vec[gi])
            );
        end
    endgenerate

    // fill / drain control and output register
    always_comb
    begin
        drain_next     = drain_reg;
        ovf_seen_next  = ovf_seen_reg;
        drain_ovf_next = drain_ovf_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (in_fire)
        begin
            if (in_data.last)
            begin
                // list ends: latch the overflow flag for the whole run
                drain_next     = 1'b1;
                drain_ovf_next = ovf_seen_reg || full;
                ovf_seen_next  = 1'b0;
                cnt_next       = '0;
            end
            else if (full)
                ovf_seen_next = 1'b1;
            else
                cnt_next = cnt_reg + CNT_W'(1);
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (load)
        begin
            out_valid_next          = 1'b1;
            out_data_next.value_res = sel_value_out;
            out_data_next.position  = asc_reg ? poss[0] : poss[MAX_ITEMS-1];
            out_data_next.last_res  = is_final;
            out_data_next.overflow  = drain_ovf_reg;
            if (is_final)
                drain_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asc_reg       <= 1'b1;
            drain_reg     <= 1'b0;
            ovf_seen_reg  <= 1'b0;
            drain_ovf_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                asc_reg <= cfg_data;
            drain_reg     <= drain_next;
            ovf_seen_reg  <= ovf_seen_next;
            drain_ovf_reg <= drain_ovf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // while filling, occupied cells form one block starting at cell 0
    a_fill_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        !drain_reg |-> ((occ & (occ + MAX_ITEMS'(1))) == '0))
        else $error("occupied cells not contiguous while filling");

    // while filling, the arrival counter matches the number of held entries
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        !drain_reg |-> ($countones(occ) == int'(cnt_reg)))
        else $error("arrival count differs from cell occupancy");

    // a drain only ends by loading the final result of the list
    a_final_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(drain_reg) |-> (out_valid && out_data.last_res))
        else $error("drain finished without a final result");

    // the chain is empty when a drain finishes
    a_empty_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(drain_reg) |-> (occ == '0))
        else $error("entries left in chain after drain");
`endif

endmodule

// ----- tb/binary_insertion_sorter_top_tb.sv -----
// testbench for the binary insertion sorter: directed rows, random lists, self-checking
module binary_insertion_sorter_top_tb;

    import bis_pkg::*;

    localparam int CAPACITY  = 64;
    localparam int LONG_HOLD = 150;
    localparam int DIR_ROWS  = 13;
    localparam int SHORT_BUDGET = 40;

    // one row of the directed walk: the transfer to send and, for lone values,
    // the single result that must come back
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     typed;
        out_item_t                res;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;

    // predictor state: the held list, kept sorted, and the output order
    logic signed [DATA_W-1:0] held_val [CAPACITY];
    logic [POS_W-1:0]         held_pos [CAPACITY];
    int                       held_cnt;
    bit                       held_dropped;
    bit                       emit_ascending;

    out_item_t sorted_run [$];   // results of the list just closed
    out_item_t sorted_due [$];   // results still to come out of the block

    int  mismatches;
    int  values_sent;
    int  lists_closed;
    int  overflow_runs;
    int  results_checked;
    int  holds_done;
    bit  hold_req;
    bit  calm;
    bit  rx_gaps;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // lone values at the extremes and -1 come straight back at position 0
        '{32'sh8000_0000, 1'b1, 1'b1, '{32'sh8000_0000, 6'd0, 1'b1, 1'b0}},
        '{32'sh7fff_ffff, 1'b1, 1'b1, '{32'sh7fff_ffff, 6'd0, 1'b1, 1'b0}},
        '{-32'sd1,        1'b1, 1'b1, '{-32'sd1,        6'd0, 1'b1, 1'b0}},
        // repeated values: order among equals follows arrival
        '{32'sd7,         1'b0, 1'b0, '0},
        '{-32'sd2,        1'b0, 1'b0, '0},
        '{32'sd7,         1'b0, 1'b0, '0},
        '{32'sd0,         1'b0, 1'b0, '0},
        '{-32'sd2,        1'b0, 1'b0, '0},
        '{32'sd7,         1'b1, 1'b0, '0},
        // both extremes twice
        '{32'sh7fff_ffff, 1'b0, 1'b0, '0},
        '{32'sh8000_0000, 1'b0, 1'b0, '0},
        '{32'sh7fff_ffff, 1'b0, 1'b0, '0},
        '{32'sh8000_0000, 1'b1, 1'b0, '0}
    };

    binary_insertion_sorter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // safety net against a hung handshake
    initial
    begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // insert one accepted value into the held list; on last, fill sorted_run
    // with the whole list in output order and start a new list
    function automatic void sort_take(in_item_t it);
        int        lo;
        int        hi;
        int        mid;
        int        k;
        int        src;
        out_item_t r;
        sorted_run.delete();
        if (held_cnt < CAPACITY)
        begin
            // first entry strictly greater, so equals stay in arrival order
            lo = 0;
            hi = held_cnt;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (it.value < held_val[mid])
                    hi = mid;
                else
                    lo = mid + 1;
            end
            for (k = held_cnt; k > lo; k--)
            begin
                held_val[k] = held_val[k-1];
                held_pos[k] = held_pos[k-1];
            end
            held_val[lo] = it.value;
            held_pos[lo] = POS_W'(held_cnt);
            held_cnt++;
        end
        else
            held_dropped = 1'b1;
        if (!it.last)
            return;
        for (k = 0; k < held_cnt; k++)
        begin
            src = emit_ascending ? k : held_cnt - 1 - k;
            r.value_res = held_val[src];
            r.position  = held_pos[src];
            r.last_res  = (k == held_cnt - 1);
            r.overflow  = held_dropped;
            sorted_run.push_back(r);
        end
        lists_closed++;
        if (held_dropped)
            overflow_runs++;
        held_cnt     = 0;
        held_dropped = 1'b0;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                // narrow range so equal values are common
                v = $urandom_range(0, 15);
                v = v - 8;
            end
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7fff_ffff;
                    2:       v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // offer one transfer, optionally after a gap, and hold it until taken
    task automatic push_item(in_item_t it, bit gaps, bit typed, out_item_t typed_res);
        int burst;
        @(negedge clk);
        if (gaps && !calm && $urandom_range(0, 3) == 0)
        begin
            burst = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (burst) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        values_sent++;
        sort_take(it);
        if (typed)
        begin
            if (it.last)
                sorted_due.push_back(typed_res);
        end
        else
            foreach (sorted_run[i])
                sorted_due.push_back(sorted_run[i]);
    endtask

    task automatic send_list(int len, bit gaps);
        in_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.value = pick_value();
            it.last  = (i == len - 1);
            push_item(it, gaps, 1'b0, '0);
        end
    endtask

    // change the output order only once the block has gone quiet
    task automatic set_order(bit asc);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge clk);
        // the drain has ended by now: descending idle shifts come before the first result
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= asc;
        do @(posedge clk); while (!cfg_ready);
        emit_ascending = asc;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // short random lists until the phase has used its share of values
    task automatic short_lists(int budget);
        int start;
        int len;
        start = values_sent;
        while (values_sent - start < budget)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_list(len, !calm && $urandom_range(0, 2) != 0);
        end
    endtask

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sorted_due.size() == 0)
            begin
                $error("unexpected result: value_res %0d position %0d",
                       out_data.value_res, out_data.position);
                mismatches++;
            end
            else
            begin
                want = sorted_due.pop_front();
                results_checked++;
                if (out_data.value_res !== want.value_res)
                begin
                    $error("value_res: expected %0d, got %0d", want.value_res, out_data.value_res);
                    mismatches++;
                end
                if (out_data.position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, out_data.position);
                    mismatches++;
                end
                if (out_data.last_res !== want.last_res)
                begin
                    $error("last_res: expected %0d, got %0d", want.last_res, out_data.last_res);
                    mismatches++;
                end
                if (out_data.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0d, got %0d", want.overflow, out_data.overflow);
                    mismatches++;
                end
            end
        end
    end

    // result side: random stall bursts in some stretches, none in others,
    // plus the long hold that backs the block up into its input
    initial
    begin
        int tick;
        int burst;
        out_ready = 1'b0;
        tick      = 0;
        rx_gaps   = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 40 == 0)
                rx_gaps = $urandom_range(0, 2) != 0;
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else if (!calm && rx_gaps && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 13);
                out_ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // main stimulus
    initial
    begin
        in_item_t it;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        rst_n     = 1'b0;
        mismatches      = 0;
        values_sent     = 0;
        lists_closed    = 0;
        overflow_runs   = 0;
        results_checked = 0;
        holds_done      = 0;
        hold_req        = 1'b0;
        calm            = 1'b0;
        held_cnt        = 0;
        held_dropped    = 1'b0;
        emit_ascending  = 1'b1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows, first in reset order (ascending), then descending
        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 1)
                set_order(1'b0);
            foreach (dir_rows[i])
            begin
                it.value = dir_rows[i].value;
                it.last  = dir_rows[i].last;
                push_item(it, 1'b0, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        // ascending: long output stall while a second list waits, then an exactly full store
        set_order(1'b1);
        hold_req = 1'b1;
        send_list(24, 1'b0);
        send_list(10, 1'b0);
        send_list(CAPACITY, 1'b1);
        short_lists(SHORT_BUDGET);

        // descending: two values past capacity, both dropped, the second one carrying last
        set_order(1'b0);
        send_list(CAPACITY + 2, 1'b1);
        short_lists(SHORT_BUDGET);

        // ascending: one value past capacity, and that one carries last
        set_order(1'b1);
        send_list(CAPACITY + 1, 1'b1);
        short_lists(SHORT_BUDGET);

        // closing stretch at full rate on both sides
        set_order(1'b0);
        calm = 1'b1;
        short_lists(SHORT_BUDGET);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge clk);
        // room for any stray result after the last expected one
        repeat (2 * CAPACITY) @(posedge clk);

        $display("sorted %0d values in %0d lists, %0d results checked, %0d lists with overflow",
                 values_sent, lists_closed, results_checked, overflow_runs);
        $display("both output orders, full and overflowing store, %0d long output stall(s)",
                 holds_done);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
